// File: rtl/core/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg: shared types and constants for the grid stroke tracker
// Request and event codes, multiplier op codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package gst_pkg;

	localparam int PATH_DEPTH = 64;
	localparam int PTR_W      = $clog2(PATH_DEPTH);
	localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_MOVE  = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_ADD    = 2'd1;
	localparam logic [1:0] EV_BACK   = 2'd2;
	localparam logic [1:0] EV_REFUSE = 2'd3;

	localparam logic REG_PITCH  = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	localparam logic [1:0] CLS_NO   = 2'd0;
	localparam logic [1:0] CLS_YES  = 2'd1;
	localparam logic [1:0] CLS_NEED = 2'd2;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_EXP  = 4'd1;
	localparam logic [3:0] OP_EYP  = 4'd2;
	localparam logic [3:0] OP_RR   = 4'd3;
	localparam logic [3:0] OP_PP   = 4'd4;
	localparam logic [3:0] OP_SXX  = 4'd5;
	localparam logic [3:0] OP_SYY  = 4'd6;
	localparam logic [3:0] OP_U    = 4'd7;
	localparam logic [3:0] OP_V    = 4'd8;
	localparam logic [3:0] OP_RD0  = 4'd9;
	localparam logic [3:0] OP_RD1  = 4'd10;
	localparam logic [3:0] OP_RD2  = 4'd11;
	localparam logic [3:0] OP_RD3  = 4'd12;
	localparam logic [3:0] OP_C0   = 4'd13;
	localparam logic [3:0] OP_C1   = 4'd14;
	localparam logic [3:0] OP_C2   = 4'd15;

	typedef struct packed {
		logic       accept;
		logic [3:0] op;
		logic       nb_ld;
		logic [2:0] nb_idx;
		logic       apply;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic       can_move;
		logic [1:0] cls;
		logic       acc_nonneg;
	} sts_t;

	// neighbor order: y outer, x inner, center skipped
	function automatic logic signed [1:0] nb_dx(input logic [2:0] i);
		case (i)
			3'd0, 3'd3, 3'd5: nb_dx = -2'sd1;
			3'd2, 3'd4, 3'd7: nb_dx = 2'sd1;
			default:          nb_dx = 2'sd0;
		endcase
	endfunction

	function automatic logic signed [1:0] nb_dy(input logic [2:0] i);
		case (i)
			3'd0, 3'd1, 3'd2: nb_dy = -2'sd1;
			3'd5, 3'd6, 3'd7: nb_dy = 2'sd1;
			default:          nb_dy = 2'sd0;
		endcase
	endfunction

endpackage

// File: rtl/core/gst_ram.sv
// ----------------------------------------------------------------------------
// gst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gst_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/gst_dp.sv
// ----------------------------------------------------------------------------
// gst_dp: grid stroke tracker datapath
// Stroke state, path RAM, shared 25x25 multiplier with accumulator,
// neighbor circle test and path update.
// ----------------------------------------------------------------------------
module gst_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  gst_pkg::cmd_t cmd,
	output gst_pkg::sts_t sts,
	input  logic [1:0]    req,
	input  logic [31:0]   pos,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [14:0]   cfg_data,
	output logic [1:0]    out_ev,
	output logic [23:0]   out_data
);

	import gst_pkg::*;

	logic [14:0]        pitch_q, radius_q;
	logic signed [15:0] pointer_x_q, pointer_y_q, origin_x_q, origin_y_q;
	logic [CNT_W-1:0]   count_q;
	logic               drawing_q;
	logic [15:0]        end_q;
	logic [1:0]         ev_q;

	logic signed [23:0] px_q, py_q, sx_q, sy_q;
	logic [29:0]        rr_q, pp_q;
	logic signed [39:0] u_q, v_q;
	logic [46:0]        dd_q;
	logic signed [79:0] acc_q, rrdd_q;
	logic signed [40:0] cr_q;
	logic [1:0]         cls_q;

	logic signed [24:0] op_a, op_b;
	logic signed [49:0] prod_s1;
	logic [3:0]         op_s1;
	logic signed [79:0] prod_x;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr, ram_raddr;
	logic [15:0]        ram_wdata, ram_rdata;

	logic signed [1:0]  dx, dy;
	logic signed [40:0] dxu, dyv, dxv, dyu;
	logic signed [41:0] fd, cr, nfd;
	logic [30:0]        fp;
	logic signed [31:0] q0;
	logic signed [49:0] q1;
	logic [1:0]         cls;

	logic signed [8:0]  nx, ny;
	logic               prev_hit, out_rng, full;
	logic [15:0]        new_cell;

	function automatic logic signed [40:0] sel1(input logic signed [1:0] s,
		input logic signed [39:0] a);
		case (s)
			2'sb01:  sel1 = {a[39], a};
			2'sb11:  sel1 = 41'sd0 - {a[39], a};
			default: sel1 = 41'sd0;
		endcase
	endfunction

	gst_ram #(.W(16), .DEPTH(PATH_DEPTH)) u_path (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_raddr = PTR_W'(count_q - CNT_W'(2));

	// multiplier operand select
	always_comb begin
		op_a = 25'sd0;
		op_b = 25'sd0;
		case (cmd.op)
			OP_EXP: begin
				op_a = {{17{end_q[7]}}, end_q[7:0]};
				op_b = {10'd0, pitch_q};
			end
			OP_EYP: begin
				op_a = {{17{end_q[15]}}, end_q[15:8]};
				op_b = {10'd0, pitch_q};
			end
			OP_RR: begin
				op_a = {10'd0, radius_q};
				op_b = {10'd0, radius_q};
			end
			OP_PP: begin
				op_a = {10'd0, pitch_q};
				op_b = {10'd0, pitch_q};
			end
			OP_SXX: begin
				op_a = {sx_q[23], sx_q};
				op_b = {sx_q[23], sx_q};
			end
			OP_SYY: begin
				op_a = {sy_q[23], sy_q};
				op_b = {sy_q[23], sy_q};
			end
			OP_U: begin
				op_a = {10'd0, pitch_q};
				op_b = {sx_q[23], sx_q};
			end
			OP_V: begin
				op_a = {10'd0, pitch_q};
				op_b = {sy_q[23], sy_q};
			end
			OP_RD0: begin
				op_a = {10'd0, rr_q[14:0]};
				op_b = {1'b0, dd_q[23:0]};
			end
			OP_RD1: begin
				op_a = {10'd0, rr_q[14:0]};
				op_b = {2'b0, dd_q[46:24]};
			end
			OP_RD2: begin
				op_a = {10'd0, rr_q[29:15]};
				op_b = {1'b0, dd_q[23:0]};
			end
			OP_RD3: begin
				op_a = {10'd0, rr_q[29:15]};
				op_b = {2'b0, dd_q[46:24]};
			end
			OP_C0: begin
				op_a = {{4{cr_q[40]}}, cr_q[40:20]};
				op_b = {{4{cr_q[40]}}, cr_q[40:20]};
			end
			OP_C1: begin
				op_a = {{4{cr_q[40]}}, cr_q[40:20]};
				op_b = {5'd0, cr_q[19:0]};
			end
			OP_C2: begin
				op_a = {5'd0, cr_q[19:0]};
				op_b = {5'd0, cr_q[19:0]};
			end
			default: begin
				op_a = 25'sd0;
				op_b = 25'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign prod_x = {{30{prod_s1[49]}}, prod_s1};

	// accumulate and save
	always_ff @(posedge clk) begin
		sx_q <= {{8{pointer_x_q[15]}}, pointer_x_q} - px_q;
		sy_q <= {{8{pointer_y_q[15]}}, pointer_y_q} - py_q;
		case (op_s1)
			OP_EXP: px_q <= prod_s1[23:0] + {{8{origin_x_q[15]}}, origin_x_q};
			OP_EYP: py_q <= prod_s1[23:0] + {{8{origin_y_q[15]}}, origin_y_q};
			OP_RR:  rr_q <= prod_s1[29:0];
			OP_PP:  pp_q <= prod_s1[29:0];
			OP_SXX: acc_q <= prod_x;
			OP_SYY: dd_q <= 47'(acc_q + prod_x);
			OP_U:   u_q <= prod_s1[39:0];
			OP_V:   v_q <= prod_s1[39:0];
			OP_RD0: acc_q <= prod_x;
			OP_RD1: acc_q <= acc_q + (prod_x <<< 24);
			OP_RD2: acc_q <= acc_q + (prod_x <<< 15);
			OP_RD3: rrdd_q <= acc_q + (prod_x <<< 39);
			OP_C0:  acc_q <= rrdd_q - (prod_x <<< 40);
			OP_C1:  acc_q <= acc_q - (prod_x <<< 21);
			OP_C2:  acc_q <= acc_q - prod_x;
			default: ;
		endcase
		if (cmd.nb_ld) begin
			cr_q <= cr[40:0];
		end
	end

	// neighbor pre-classification from per-item terms
	always_comb begin
		dx  = nb_dx(cmd.nb_idx);
		dy  = nb_dy(cmd.nb_idx);
		dxu = sel1(dx, u_q);
		dyv = sel1(dy, v_q);
		dxv = sel1(dx, v_q);
		dyu = sel1(dy, u_q);
		fd  = 42'sd0 - ({dxu[40], dxu} + {dyv[40], dyv});
		cr  = {dxv[40], dxv} - {dyu[40], dyu};
		nfd = 42'sd0 - fd;
		fp  = (dx != 2'sd0 && dy != 2'sd0) ? {pp_q, 1'b0} : {1'b0, pp_q};
		q0  = {1'b0, fp} - {2'b0, rr_q};
		q1  = {3'b0, dd_q} + {{7{fd[41]}}, fd, 1'b0} + {{18{q0[31]}}, q0};
		if (dd_q == 47'd0) begin
			cls = CLS_NO;
		end else if (q0[31] && q1[49]) begin
			cls = CLS_NO;
		end else if (q0[31] || q0 == 32'sd0 || q1[49] || q1 == 50'sd0) begin
			cls = CLS_YES;
		end else if (!fd[41] || {5'd0, nfd} >= dd_q) begin
			cls = CLS_NO;
		end else begin
			cls = CLS_NEED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q <= CLS_NO;
		end else if (cmd.nb_ld) begin
			cls_q <= cls;
		end
	end

	// path update
	always_comb begin
		nx       = {end_q[7], end_q[7:0]} + {{7{dx[1]}}, dx};
		ny       = {end_q[15], end_q[15:8]} + {{7{dy[1]}}, dy};
		prev_hit = (count_q >= CNT_W'(2)) &&
			({ram_rdata[7], ram_rdata[7:0]} == nx) &&
			({ram_rdata[15], ram_rdata[15:8]} == ny);
		out_rng  = (nx[8] != nx[7]) || (ny[8] != ny[7]);
		full     = count_q >= CNT_W'(PATH_DEPTH);
		new_cell = {ny[7:0], nx[7:0]};
		ram_we    = 1'b0;
		ram_waddr = PTR_W'(count_q);
		ram_wdata = new_cell;
		if (cmd.accept && req == REQ_START) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = 16'd0;
		end else if (cmd.apply && !prev_hit && !out_rng && !full) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q     <= 15'd512;
			radius_q    <= 15'd128;
			pointer_x_q <= '0;
			pointer_y_q <= '0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			count_q     <= '0;
			drawing_q   <= 1'b0;
			end_q       <= '0;
			ev_q        <= EV_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PITCH:  pitch_q <= cfg_data;
					REG_RADIUS: radius_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				ev_q <= EV_NONE;
				case (req)
					REQ_START: begin
						drawing_q  <= 1'b1;
						origin_x_q <= pointer_x_q;
						origin_y_q <= pointer_y_q;
						end_q      <= 16'd0;
						count_q    <= CNT_W'(1);
					end
					REQ_MOVE: begin
						pointer_x_q <= pos[15:0];
						pointer_y_q <= pos[31:16];
					end
					REQ_END: drawing_q <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				if (prev_hit) begin
					count_q <= count_q - CNT_W'(1);
					end_q   <= ram_rdata;
					ev_q    <= EV_BACK;
				end else if (out_rng || full) begin
					ev_q <= EV_REFUSE;
				end else begin
					count_q <= count_q + CNT_W'(1);
					end_q   <= new_cell;
					ev_q    <= EV_ADD;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_ev   <= ev_q;
			out_data <= {drawing_q, 7'(count_q), end_q};
		end
	end

	assign sts.can_move   = drawing_q && (count_q != '0);
	assign sts.cls        = cls_q;
	assign sts.acc_nonneg = !acc_q[79];

endmodule

// File: rtl/core/gst_ctrl.sv
// ----------------------------------------------------------------------------
// gst_ctrl: grid stroke tracker controller
// Sequences per-item products, the neighbor tests and the output handshake.
// ----------------------------------------------------------------------------
module gst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [1:0]    req,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  gst_pkg::sts_t sts,
	output gst_pkg::cmd_t cmd
);

	import gst_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PRE   = 4'd1;
	localparam logic [3:0] ST_NB    = 4'd2;
	localparam logic [3:0] ST_CLS   = 4'd3;
	localparam logic [3:0] ST_C1    = 4'd4;
	localparam logic [3:0] ST_C2    = 4'd5;
	localparam logic [3:0] ST_CW    = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_APPLY = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	localparam logic [3:0] PRE_LAST = 4'd12;

	logic [3:0] state_q, state_d;
	logic [3:0] step_q, step_d;
	logic [2:0] nb_q, nb_d;
	logic       mvalid_q, mvalid_d;

	function automatic logic [3:0] pre_op(input logic [3:0] s);
		case (s)
			4'd0:    pre_op = OP_EXP;
			4'd1:    pre_op = OP_EYP;
			4'd2:    pre_op = OP_RR;
			4'd3:    pre_op = OP_PP;
			4'd4:    pre_op = OP_SXX;
			4'd5:    pre_op = OP_SYY;
			4'd6:    pre_op = OP_U;
			4'd7:    pre_op = OP_V;
			4'd8:    pre_op = OP_RD0;
			4'd9:    pre_op = OP_RD1;
			4'd10:   pre_op = OP_RD2;
			4'd11:   pre_op = OP_RD3;
			default: pre_op = OP_NONE;
		endcase
	endfunction

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		nb_d       = nb_q;
		mvalid_d   = mvalid_q && !m_tready;
		cmd        = '0;
		cmd.op     = OP_NONE;
		cmd.nb_idx = nb_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					step_d     = 4'd0;
					if (req == REQ_MOVE && sts.can_move) begin
						state_d = ST_PRE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PRE: begin
				cmd.op = pre_op(step_q);
				step_d = step_q + 4'd1;
				if (step_q == PRE_LAST) begin
					nb_d    = 3'd0;
					state_d = ST_NB;
				end
			end
			ST_NB: begin
				cmd.nb_ld = 1'b1;
				state_d   = ST_CLS;
			end
			ST_CLS: begin
				case (sts.cls)
					CLS_YES: state_d = ST_APPLY;
					CLS_NEED: begin
						cmd.op  = OP_C0;
						state_d = ST_C1;
					end
					default: begin
						nb_d    = nb_q + 3'd1;
						state_d = (nb_q == 3'd7) ? ST_DONE : ST_NB;
					end
				endcase
			end
			ST_C1: begin
				cmd.op  = OP_C1;
				state_d = ST_C2;
			end
			ST_C2: begin
				cmd.op  = OP_C2;
				state_d = ST_CW;
			end
			ST_CW: state_d = ST_CHK;
			ST_CHK: begin
				if (sts.acc_nonneg) begin
					state_d = ST_APPLY;
				end else begin
					nb_d    = nb_q + 3'd1;
					state_d = (nb_q == 3'd7) ? ST_DONE : ST_NB;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!mvalid_q || m_tready) begin
					cmd.out_ld = 1'b1;
					mvalid_d   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			nb_q     <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			nb_q     <= nb_d;
			mvalid_q <= mvalid_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

endmodule

// File: rtl/core/grid_stroke_tracker.sv
// ----------------------------------------------------------------------------
// grid_stroke_tracker: snaps a pointer stroke onto a grid of dots
// Start, move and end words update the path; one result word per input word.
// Start, end and idle-move words go straight to the output load; a drawing move
// first runs its products on the one shared 25x25 multiplier, then tests the
// neighbors in turn and applies the step to the first neighbor that is hit.
// One word is in work at a time: the next word is accepted only after the
// result is loaded; the output register frees the input side while a result waits.
// Reset clears stroke state and path count and sets pitch and radius to their defaults.
// ----------------------------------------------------------------------------
module grid_stroke_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pos_x[15:0], pos_y[31:16]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // cell_x[7:0], cell_y[15:8], path_len[22:16], drawing[23]
	output logic [1:0]  m_tuser,   // event_res[1:0]
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [14:0] cfg_data
);

	import gst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req      (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (s_tuser),
		.pos      (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.out_ev   (m_tuser),
		.out_data (m_tdata)
	);

endmodule

// File: verif/grid_stroke_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_stroke_tracker_test: self-checking bench for the grid stroke tracker
// Drives start, move and end words through the input stream, with moves
// mostly aimed at neighbor dots. The expected path state is computed as each
// word is queued. Both stream sides idle at random, and the pitch and radius
// registers change between phases, the extremes among them.
// ----------------------------------------------------------------------------
module grid_stroke_tracker_test;
	import gst_pkg::*;

	typedef struct packed {
		logic [1:0]  req;
		logic [15:0] px;
		logic [15:0] py;
	} stroke_word_t;

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] cx;
		logic [7:0] cy;
		logic [6:0] len;
		logic       drw;
	} track_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [14:0] cfg_data = '0;

	grid_stroke_tracker uut (.*);

	stroke_word_t pending_q[$];
	track_word_t  track_q[$];
	int           sent_cnt = 0;
	int           acc_cnt = 0;
	int           err_cnt = 0;
	int           idle_cyc = 0;
	int           in_gap = 0;
	int           out_gap = 0;

	// tracker state as predicted
	logic [15:0] cells[PATH_DEPTH];
	int          cnt;
	bit          drawing;
	longint      ptr_x, ptr_y, org_x, org_y, pitch, radius;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint cxof(logic [15:0] c);
		return longint'($signed(c[7:0]));
	endfunction

	function automatic longint cyof(logic [15:0] c);
		return longint'($signed(c[15:8]));
	endfunction

	function automatic bit dot_hit(longint ex, longint ey, longint dx, longint dy);
		longint px, py, fx, fy, sx, sy, dd, rr, q0, q1, gx, gy, fd, cr;
		logic [127:0] a2, b2;
		px = ex * pitch + org_x;
		py = ey * pitch + org_y;
		fx = -dx * pitch;
		fy = -dy * pitch;
		sx = ptr_x - px;
		sy = ptr_y - py;
		dd = sx * sx + sy * sy;
		rr = radius * radius;
		if (dd == 0)
			return 0;
		q0 = fx * fx + fy * fy - rr;
		gx = sx + fx;
		gy = sy + fy;
		q1 = gx * gx + gy * gy - rr;
		if (q0 < 0 && q1 < 0)
			return 0;
		if (q0 <= 0 || q1 <= 0)
			return 1;
		fd = fx * sx + fy * sy;
		if (fd >= 0 || -fd >= dd)
			return 0;
		cr = fx * sy - fy * sx;
		if (cr < 0)
			cr = -cr;
		a2 = 128'(cr) * 128'(cr);
		b2 = 128'(rr) * 128'(dd);
		return a2 <= b2;
	endfunction

	function automatic track_word_t track_step(stroke_word_t w);
		track_word_t r;
		longint ex, ey, nx, ny;
		bit found;
		r = '0;
		r.ev = EV_NONE;
		if (w.req == REQ_START) begin
			drawing = 1;
			org_x = ptr_x;
			org_y = ptr_y;
			cells[0] = '0;
			cnt = 1;
		end else if (w.req == REQ_END) begin
			drawing = 0;
		end else if (w.req == REQ_MOVE) begin
			ptr_x = longint'($signed(w.px));
			ptr_y = longint'($signed(w.py));
			if (drawing && cnt > 0) begin
				ex = cxof(cells[cnt-1]);
				ey = cyof(cells[cnt-1]);
				found = 0;
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						if (!found && !(dx == 0 && dy == 0) && dot_hit(ex, ey, dx, dy)) begin
							found = 1;
							nx = ex + dx;
							ny = ey + dy;
							if (cnt >= 2 && cxof(cells[cnt-2]) == nx && cyof(cells[cnt-2]) == ny) begin
								cnt--;
								r.ev = EV_BACK;
							end else if (nx < -128 || nx > 127 || ny < -128 || ny > 127 ||
									cnt >= PATH_DEPTH) begin
								r.ev = EV_REFUSE;
							end else begin
								cells[cnt] = {ny[7:0], nx[7:0]};
								cnt++;
								r.ev = EV_ADD;
							end
						end
					end
				end
			end
		end
		if (cnt > 0) begin
			r.cx = cells[cnt-1][7:0];
			r.cy = cells[cnt-1][15:8];
		end
		r.len = cnt[6:0];
		r.drw = drawing;
		return r;
	endfunction

	task automatic queue_word(logic [1:0] req, longint x, longint y);
		stroke_word_t w;
		w.req = req;
		w.px = x[15:0];
		w.py = y[15:0];
		track_q.push_back(track_step(w));
		pending_q.push_back(w);
	endtask

	// aim at a neighbor of the path end; dx = dy = 0 aims at the end center itself
	task automatic aim_move(int dx, int dy, int jit);
		longint ex, ey, jx, jy;
		ex = (cnt > 0) ? cxof(cells[cnt-1]) : 0;
		ey = (cnt > 0) ? cyof(cells[cnt-1]) : 0;
		jx = (jit > 0) ? longint'($urandom_range(2 * jit)) - jit : 0;
		jy = (jit > 0) ? longint'($urandom_range(2 * jit)) - jit : 0;
		queue_word(REQ_MOVE, org_x + (ex + dx) * pitch + jx, org_y + (ey + dy) * pitch + jy);
	endtask

	task automatic wait_drain();
		wait (pending_q.size() == 0 && track_q.size() == 0 && acc_cnt == sent_cnt);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[14:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PITCH)
			pitch = val;
		else
			radius = val;
	endtask

	task automatic random_stroke(int n, bit straight);
		int sel, k;
		queue_word(REQ_MOVE, longint'($urandom_range(65535)) - 32768,
			longint'($urandom_range(65535)) - 32768);
		queue_word(REQ_START, longint'($urandom), longint'($urandom));
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (straight) begin
				aim_move(1, 0, 0);
			end else if (sel < 70) begin
				k = $urandom_range(7);
				if (k >= 4)
					k++;
				aim_move(k % 3 - 1, k / 3 - 1, int'(radius));
			end else if (sel < 85) begin
				aim_move(0, 0, int'(pitch) * 2);
			end else if (sel < 92) begin
				aim_move(0, 0, 0);
			end else begin
				queue_word(2'($urandom_range(3)), longint'($urandom), longint'($urandom));
			end
		end
		queue_word(REQ_END, longint'($urandom), longint'($urandom));
	endtask

	int cfg_p[5] = '{512, 1, 32767, 64, 16};
	int cfg_r[5] = '{128, 0, 32767, 20, 6};

	initial begin
		cnt = 0;
		drawing = 0;
		ptr_x = 0;
		ptr_y = 0;
		org_x = 0;
		org_y = 0;
		pitch = 512;
		radius = 128;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed
		queue_word(REQ_MOVE, 32767, -32768);
		queue_word(REQ_END, 0, 0);
		queue_word(2'd3, 16'hFFFF, 16'hFFFF);
		queue_word(REQ_MOVE, -32768, 32767);
		queue_word(REQ_MOVE, 0, 0);
		queue_word(REQ_START, 0, 0);
		aim_move(0, 0, 0);
		aim_move(1, 0, 0);
		aim_move(-1, 0, 0);
		aim_move(-1, -1, 0);
		aim_move(1, 1, 0);
		aim_move(0, 1, 0);
		aim_move(0, -1, 0);
		aim_move(1, -1, 0);
		aim_move(-1, 1, 0);
		queue_word(2'd3, 0, 0);
		aim_move(0, 0, 3000);
		queue_word(REQ_END, 0, 0);
		aim_move(1, 0, 0);
		queue_word(REQ_START, 0, 0);
		queue_word(REQ_MOVE, 32767, 32767);
		queue_word(REQ_MOVE, -32768, -32768);
		queue_word(REQ_END, 0, 0);
		wait_drain();
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_PITCH, cfg_p[ph]);
			write_reg(REG_RADIUS, cfg_r[ph]);
			if (ph == 4)
				random_stroke(70, 1);
			for (int n = 0; n < 360; ) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 3);
				random_stroke(len, $urandom_range(19) == 0);
				n += len + 3;
			end
			wait_drain();
		end
		if (err_cnt == 0)
			$display("grid_stroke_tracker_test: done, clean");
		else
			$display("grid_stroke_tracker_test: done, errors");
		$finish;
	end

	function automatic int pick_gap();
		int g;
		g = $urandom_range(99);
		if (g < 50)
			return 0;
		if (g < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// input driver
	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && acc_cnt != sent_cnt)) begin
		end else if (in_gap > 0) begin
			s_tvalid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_q.size() > 0) begin
			stroke_word_t w;
			w = pending_q.pop_front();
			s_tuser <= w.req;
			s_tdata <= {w.py, w.px};
			s_tvalid <= 1'b1;
			sent_cnt <= sent_cnt + 1;
			in_gap <= pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// output stall
	always @(negedge clk) begin
		if (out_gap > 0) begin
			m_tready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			m_tready <= 1'b1;
			out_gap <= pick_gap();
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			acc_cnt <= acc_cnt + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= 3000) begin
			$display("grid_stroke_tracker_test: done, errors");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			track_word_t got, exp_w;
			got.ev = m_tuser;
			got.cx = m_tdata[7:0];
			got.cy = m_tdata[15:8];
			got.len = m_tdata[22:16];
			got.drw = m_tdata[23];
			if (track_q.size() == 0) begin
				$display("%0t: unexpected word ev=%0d x=%0d y=%0d len=%0d drw=%0d", $time,
					got.ev, $signed(got.cx), $signed(got.cy), got.len, got.drw);
				err_cnt <= err_cnt + 1;
			end else begin
				exp_w = track_q.pop_front();
				if (got !== exp_w) begin
					$display("%0t: expected ev=%0d x=%0d y=%0d len=%0d drw=%0d", $time,
						exp_w.ev, $signed(exp_w.cx), $signed(exp_w.cy), exp_w.len, exp_w.drw);
					$display("%0t: actual   ev=%0d x=%0d y=%0d len=%0d drw=%0d", $time,
						got.ev, $signed(got.cx), $signed(got.cy), got.len, got.drw);
					err_cnt <= err_cnt + 1;
				end
			end
		end
	end

endmodule

// File: filelist.f
rtl/core/gst_pkg.sv
rtl/core/gst_ram.sv
rtl/core/gst_dp.sv
rtl/core/gst_ctrl.sv
rtl/core/grid_stroke_tracker.sv
verif/grid_stroke_tracker_test.sv
